FILE: src/pss_pkg.sv
// shared constants and types for the function signature scanner
package pss_pkg;

	localparam int unsigned MAX_IMAGE_WORDS = 8388608;
	localparam int unsigned POS_W = 24;
	localparam int unsigned LEN_W = 26;
	localparam int unsigned OUT_TDATA_W = 96;

	localparam logic [31:0] BLR_WORD = 32'h4e80_0020;
	localparam logic [31:0] PRIMARY_MASK = 32'hFC00_0000;
	localparam logic [31:0] SUB_LOW_MASK = 32'h0000_003F;
	localparam logic [31:0] EXT_MASK = 32'h0000_07C0;
	localparam logic [31:0] FIELD_MASK = 32'h03FF_0000;
	localparam logic [31:0] XO_MASK = 32'h0000_07FF;
	localparam logic [31:0] SUM_HIGH_MASK = 32'hFFFE_0000;
	localparam logic [31:0] SUM_LOW_MASK = 32'h0001_FFFF;
	localparam int unsigned ROT_AMOUNT = 17;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_IMAGE_WORDS - 1);

	// primary opcodes that pick a mask
	localparam logic [5:0] OP_VEC = 6'd4;
	localparam logic [5:0] OP_MULLI = 6'd7;
	localparam logic [5:0] OP_SUBFIC = 6'd8;
	localparam logic [5:0] OP_CMPLI = 6'd10;
	localparam logic [5:0] OP_ADDIS = 6'd15;
	localparam logic [5:0] OP_GRP19 = 6'd19;
	localparam logic [5:0] OP_GRP31 = 6'd31;
	localparam logic [5:0] OP_LWZ = 6'd32;
	localparam logic [5:0] OP_FP59 = 6'd59;
	localparam logic [5:0] OP_LOADSTORE_END = 6'd56;
	localparam logic [5:0] OP_FP63 = 6'd63;

	// one finished function
	typedef struct packed {
		logic [31:0] function_address;
		logic [LEN_W-1:0] length_bytes;
		logic [31:0] signature;
		logic unterminated;
		logic ends_image;
	} pss_result_t;

endpackage

FILE: src/ppc_function_signature_scanner.sv
// top level of the powerpc function signature scanner
//
// Takes a code image one 32-bit instruction word per transfer on the s_ side
// (s_tlast marks the image's last word) and returns one transfer on the m_
// side per function found: start address, byte length and a rotate-xor
// checksum of the masked opcode bits. m_tuser flags a function cut off by
// the end of the image, m_tlast marks a result caused by the last word.
// base_address is to be written on the cfg_ channel while the block is idle;
// the block itself does not enforce this. Timing: a word sits in the input
// register while the checksum update runs, then lands in the result register,
// which drives m_tvalid for the function that the word closes. One word is
// taken every cycle while the receiver keeps up; the rate is set by the
// combinational rotate-xor update of the running sum. When the receiver
// stalls, the result register holds and the input register fills, after
// which s_tready drops until the result leaves.
// Reset clears the scan state and base_address, and the first word after
// reset or after a last word opens a new function at offset zero.
module ppc_function_signature_scanner (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata, // [31:0] instruction_word
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	// [31:0] function_address, [57:32] length_bytes, [89:58] signature, rest zero
	output logic [pss_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic m_tuser, // [0] unterminated
	output logic m_tlast,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [31:0] cfg_data
);
	import pss_pkg::*;

	logic [31:0] base_address_q;
	logic in_valid_s1;
	logic [31:0] in_word_s1;
	logic in_last_s1;
	logic core_ready;
	logic core_valid;
	pss_result_t core_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			base_address_q <= cfg_data;
		end
	end

	assign s_tready = !in_valid_s1 || core_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_word_s1 <= s_tdata;
			in_last_s1 <= s_tlast;
		end
	end

	pss_scan_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.base_address(base_address_q),
		.item_valid(in_valid_s1),
		.item_word(in_word_s1),
		.item_last(in_last_s1),
		.item_ready(core_ready),
		.res_valid(core_valid),
		.res_ready(m_tready),
		.res(core_res)
	);

	assign m_tvalid = core_valid;
	assign m_tdata = {6'd0, core_res.signature, core_res.length_bytes,
		core_res.function_address};
	assign m_tuser = core_res.unterminated;
	assign m_tlast = core_res.ends_image;

	// an unterminated function can only come from the image's last word
	a_unterm_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("unterminated result without last");

	// every function holds at least one word
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[57:32] != '0)
		else $error("zero length result");

	// backpressure on the input only while the input register is occupied
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> in_valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a full pipeline");

endmodule

FILE: src/pss_opcode_mask.sv
// reduces one instruction word to its opcode bits
module pss_opcode_mask (
	input logic [31:0] word,
	output logic [31:0] opcode_bits
);
	import pss_pkg::*;

	logic [5:0] primary;
	logic [31:0] sub;
	logic [31:0] ext;
	logic [5:0] low6;

	assign primary = word[31:26];
	assign low6 = word[5:0];

	always_comb begin
		sub = '0;
		ext = '0;
		if (primary == OP_VEC) begin
			sub = word & SUB_LOW_MASK;
			if (low6 == 6'd0 || low6 == 6'd8 || low6 == 6'd16 || low6 == 6'd21
				|| low6 == 6'd22) begin
				ext = word & EXT_MASK;
			end
		end else if (primary == OP_MULLI || primary == OP_SUBFIC
			|| (primary >= OP_CMPLI && primary <= OP_ADDIS)) begin
			sub = word & FIELD_MASK;
		end else if (primary == OP_GRP19 || primary == OP_GRP31 || primary == OP_FP63) begin
			sub = word & XO_MASK;
		end else if (primary == OP_FP59) begin
			sub = word & SUB_LOW_MASK;
			if (low6 < 6'd16) begin
				ext = word & EXT_MASK;
			end
		end else if (primary >= OP_LWZ && primary < OP_LOADSTORE_END) begin
			sub = word & FIELD_MASK;
		end
	end

	assign opcode_bits = (word & PRIMARY_MASK) | sub | ext;

endmodule

FILE: src/pss_scan_core.sv
// scan state, checksum update and result register
module pss_scan_core (
	input logic clk,
	input logic arst_n,
	input logic [31:0] base_address,
	input logic item_valid,
	input logic [31:0] item_word,
	input logic item_last,
	output logic item_ready,
	output logic res_valid,
	input logic res_ready,
	output pss_pkg::pss_result_t res
);
	import pss_pkg::*;

	logic scan_mode_q;
	logic [31:0] running_sum_q;
	logic [POS_W-1:0] word_position_q;
	logic [POS_W-1:0] start_position_q;
	logic res_valid_q;
	pss_result_t res_q;

	logic fire;
	logic is_blr;
	logic mode_open;
	logic emit;
	logic [31:0] sum_base;
	logic [31:0] sum_rot;
	logic [31:0] sum_next;
	logic [31:0] op_bits;
	logic [POS_W-1:0] start_eff;
	logic [POS_W-1:0] span;
	logic [POS_W-1:0] words;
	pss_result_t res_next;

	pss_opcode_mask u_mask (
		.word(item_word),
		.opcode_bits(op_bits)
	);

	assign item_ready = !res_valid_q || res_ready;
	assign fire = item_valid && item_ready;

	assign is_blr = (item_word == BLR_WORD);
	// a nonzero word reopens a function while skipping
	assign mode_open = scan_mode_q || (item_word != '0);
	assign sum_base = scan_mode_q ? running_sum_q : '0;
	assign start_eff = scan_mode_q ? start_position_q : word_position_q;
	assign sum_rot = ((sum_base << ROT_AMOUNT) & SUM_HIGH_MASK)
		| ((sum_base >> (32 - ROT_AMOUNT)) & SUM_LOW_MASK);
	assign sum_next = sum_rot ^ op_bits;
	assign emit = mode_open && (is_blr || item_last);

	assign span = word_position_q - start_eff;
	// the word count stays within POS_W bits, so the x4 length fits LEN_W without wrapping
	assign words = span + POS_W'(1);

	always_comb begin
		res_next.function_address = base_address + {6'd0, start_eff, 2'b00};
		res_next.length_bytes = {words, 2'b00};
		res_next.signature = sum_next;
		res_next.unterminated = !is_blr;
		res_next.ends_image = item_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q <= 1'b1;
			running_sum_q <= '0;
			word_position_q <= '0;
			start_position_q <= '0;
		end else if (fire) begin
			if (item_last) begin
				scan_mode_q <= 1'b1;
				running_sum_q <= '0;
				word_position_q <= '0;
				start_position_q <= '0;
			end else begin
				scan_mode_q <= mode_open && !emit;
				if (mode_open) begin
					running_sum_q <= sum_next;
				end
				start_position_q <= start_eff;
				if (word_position_q < POS_LAST) begin
					word_position_q <= word_position_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= emit;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

FILE: tb/sv/ppc_function_signature_scanner_tb.sv
// testbench for the powerpc function signature scanner: directed table, then random images
`timescale 1ns / 100ps

module ppc_function_signature_scanner_tb;
	import pss_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 650;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIR_N = 25;

	// vector sub-opcodes that also keep the extended field
	localparam logic [5:0] VEC_SUB_VADD = 6'd0;
	localparam logic [5:0] VEC_SUB_VMUL = 6'd8;
	localparam logic [5:0] VEC_SUB_VSEL = 6'd16;
	localparam logic [5:0] VEC_SUB_VSPLT = 6'd21;
	localparam logic [5:0] VEC_SUB_VPERM = 6'd22;
	localparam logic [31:0] FP59_EXT_LIMIT = 32'd16;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_RESULT, ROW_QUIET} row_kind_t;

	typedef struct {
		logic [31:0] word;
		logic last;
		row_kind_t kind;
		pss_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	// scanner state as the block should hold it
	logic [31:0] base_addr = '0;
	logic in_function = 1'b1;
	logic [31:0] running_sum = '0;
	logic [POS_W-1:0] word_pos = '0;
	logic [POS_W-1:0] start_pos = '0;

	pss_result_t pending_functions[$];
	stim_row_t dir_rows [DIR_N];

	int send_idle = 26;
	int recv_idle = 68;
	int cycles = 0;
	int mismatches = 0;
	int words_sent = 0;
	int functions_seen = 0;
	int cut_functions = 0;
	int images = 0;
	int base_writes = 0;

	ppc_function_signature_scanner dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d functions pending", cycles,
				pending_functions.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] masked_opcode(input logic [31:0] w);
		logic [5:0] prim;
		logic [31:0] sub;
		logic [31:0] ext;
		prim = w[31:26];
		sub = '0;
		ext = '0;
		if (prim == OP_VEC) begin
			sub = w & SUB_LOW_MASK;
			if (sub[5:0] == VEC_SUB_VADD || sub[5:0] == VEC_SUB_VMUL || sub[5:0] == VEC_SUB_VSEL ||
					sub[5:0] == VEC_SUB_VSPLT || sub[5:0] == VEC_SUB_VPERM)
				ext = w & EXT_MASK;
		end else if (prim == OP_MULLI || prim == OP_SUBFIC ||
				(prim >= OP_CMPLI && prim <= OP_ADDIS)) begin
			sub = w & FIELD_MASK;
		end else if (prim == OP_GRP19 || prim == OP_GRP31 || prim == OP_FP63) begin
			sub = w & XO_MASK;
		end else if (prim == OP_FP59) begin
			sub = w & SUB_LOW_MASK;
			if (sub < FP59_EXT_LIMIT)
				ext = w & EXT_MASK;
		end else if (prim >= OP_LWZ && prim < OP_LOADSTORE_END) begin
			sub = w & FIELD_MASK;
		end
		return (w & PRIMARY_MASK) | sub | ext;
	endfunction

	// advance the scan by one word, returns 1 when a function closes
	function automatic bit scan_word(input logic [31:0] w, input logic last,
			output pss_result_t fn);
		bit closed;
		logic [POS_W-1:0] pos;
		logic [31:0] nwords;
		closed = 1'b0;
		fn = '0;
		pos = word_pos;
		if (!in_function && w != 32'd0) begin
			in_function = 1'b1;
			running_sum = '0;
			start_pos = pos;
		end
		if (in_function) begin
			running_sum = {running_sum[14:0], running_sum[31:15]} ^ masked_opcode(w);
			if (w == BLR_WORD || last) begin
				nwords = {8'd0, POS_W'(pos - start_pos)} + 32'd1;
				fn.function_address = base_addr + {6'd0, start_pos, 2'b00};
				fn.length_bytes = LEN_W'(nwords << 2);
				fn.signature = running_sum;
				fn.unterminated = (w != BLR_WORD);
				fn.ends_image = last;
				closed = 1'b1;
				in_function = 1'b0;
			end
		end
		if (last) begin
			in_function = 1'b1;
			running_sum = '0;
			word_pos = '0;
			start_pos = '0;
		end else if (pos < POS_LAST) begin
			word_pos = pos + POS_W'(1);
		end
		return closed;
	endfunction

	function automatic void expect_function(input pss_result_t fn);
		pending_functions = {pending_functions, fn};
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		pss_result_t got;
		pss_result_t want;
		if (m_tvalid && m_tready) begin
			got.function_address = m_tdata[31:0];
			got.length_bytes = m_tdata[57:32];
			got.signature = m_tdata[89:58];
			got.unterminated = m_tuser;
			got.ends_image = m_tlast;
			if (pending_functions.size() == 0) begin
				$display("%0t ns: unexpected function expected none got %h %h %h %b %b", $time,
					got.function_address, got.length_bytes, got.signature, got.unterminated,
					got.ends_image);
				mismatches++;
			end else begin
				want = pending_functions.pop_front();
				check_field("function_address", want.function_address, got.function_address);
				check_field("length_bytes", 32'(want.length_bytes), 32'(got.length_bytes));
				check_field("signature", want.signature, got.signature);
				check_field("unterminated", 32'(want.unterminated), 32'(got.unterminated));
				check_field("ends_image", 32'(want.ends_image), 32'(got.ends_image));
				functions_seen++;
				if (got.unterminated)
					cut_functions++;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// valid stays up between back-to-back words, lowered only for a gap
	task automatic send_word(input logic [31:0] w, input logic last);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	task automatic scan_and_send(input logic [31:0] w, input logic last);
		pss_result_t fn;
		send_word(w, last);
		if (scan_word(w, last, fn))
			expect_function(fn);
	endtask

	// an image can end with no function open, so allow for work still inside
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_functions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_addr = value;
		base_writes++;
	endtask

	function automatic logic [31:0] pick_base();
		case ($urandom_range(4))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'hFFFF_FFFC;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] gen_instr();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(9))
			0: begin
				w[31:26] = OP_VEC;
				case ($urandom_range(5))
					0: w[5:0] = VEC_SUB_VADD;
					1: w[5:0] = VEC_SUB_VMUL;
					2: w[5:0] = VEC_SUB_VSEL;
					3: w[5:0] = VEC_SUB_VSPLT;
					4: w[5:0] = VEC_SUB_VPERM;
					default: ;
				endcase
			end
			1: begin
				case ($urandom_range(2))
					0: w[31:26] = OP_MULLI;
					1: w[31:26] = OP_SUBFIC;
					default: w[31:26] = 6'($urandom_range(OP_CMPLI, OP_ADDIS));
				endcase
			end
			2: begin
				case ($urandom_range(2))
					0: w[31:26] = OP_GRP19;
					1: w[31:26] = OP_GRP31;
					default: w[31:26] = OP_FP63;
				endcase
			end
			3: w[31:26] = OP_FP59;
			4: w[31:26] = 6'($urandom_range(OP_LWZ, OP_LOADSTORE_END - 1));
			5: w = 32'd0;
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [31:0] gen_opener();
		logic [31:0] w;
		do w = gen_instr(); while (w == 32'd0 || w == BLR_WORD);
		return w;
	endfunction

	task automatic run_image();
		logic [31:0] img[$];
		int nfunc;
		int body;
		int k;
		if ($urandom_range(7) == 0) begin
			// noise: raw words with the odd blr and zero mixed in
			for (k = 0; k < $urandom_range(1, 24); k++) begin
				case ($urandom_range(9))
					0: img = {img, BLR_WORD};
					1: img = {img, 32'd0};
					default: img = {img, 32'($urandom)};
				endcase
			end
		end else begin
			if ($urandom_range(5) == 0)
				img = {img, 32'd0};
			nfunc = $urandom_range(1, 4);
			for (int f = 0; f < nfunc; f++) begin
				if (f != 0 || img.size() == 0)
					img = {img, gen_opener()};
				body = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
				for (k = 0; k < body; k++)
					img = {img, gen_instr()};
				img = {img, BLR_WORD};
				if (f != nfunc - 1)
					for (k = 0; k < $urandom_range(0, 3); k++)
						img = {img, 32'd0};
			end
			case ($urandom_range(2))
				// image cut inside a function
				0: begin
					img = {img, gen_opener()};
					for (k = 0; k < $urandom_range(0, 4); k++)
						img = {img, gen_instr()};
				end
				// image ends among the zeros after a function
				1: begin
					for (k = 0; k < $urandom_range(1, 3); k++)
						img = {img, 32'd0};
				end
				default: ;
			endcase
		end
		foreach (img[i])
			scan_and_send(img[i], i == img.size() - 1);
		images++;
	endtask

	initial begin
		int target;
		dir_rows = '{
			'{BLR_WORD, 1'b0, ROW_RESULT, '{32'h0, 26'd4, 32'h4C00_0020, 1'b0, 1'b0}},
			'{32'h0000_0000, 1'b0, ROW_QUIET, '0},
			'{32'hFFFF_FFFF, 1'b0, ROW_PREDICT, '0},
			'{32'h1000_0000, 1'b0, ROW_PREDICT, '0},
			'{32'h1000_07C8, 1'b0, ROW_PREDICT, '0},
			'{32'h1123_4550, 1'b0, ROW_PREDICT, '0},
			'{32'h1000_07D5, 1'b0, ROW_PREDICT, '0},
			'{32'h1000_07D6, 1'b0, ROW_PREDICT, '0},
			'{32'h1000_07C5, 1'b0, ROW_PREDICT, '0},
			'{32'h1FFF_FFFF, 1'b0, ROW_PREDICT, '0},
			'{32'h2BFF_FFFF, 1'b0, ROW_PREDICT, '0},
			'{32'hEC00_07CF, 1'b0, ROW_PREDICT, '0},
			'{32'hEFFF_FFFF, 1'b0, ROW_PREDICT, '0},
			'{32'h83E1_FFFF, 1'b0, ROW_PREDICT, '0},
			'{32'hE3FF_FFFF, 1'b0, ROW_PREDICT, '0},
			'{32'h07FF_FFFF, 1'b0, ROW_PREDICT, '0},
			'{BLR_WORD, 1'b0, ROW_PREDICT, '0},
			// image ends while skipping zeros
			'{32'h0000_0000, 1'b1, ROW_QUIET, '0},
			// a lone zero word is still a function of its own
			'{32'h0000_0000, 1'b1, ROW_RESULT, '{32'h0, 26'd4, 32'h0, 1'b1, 1'b1}},
			'{BLR_WORD, 1'b1, ROW_RESULT, '{32'h0, 26'd4, 32'h4C00_0020, 1'b0, 1'b1}},
			'{32'h3960_0000, 1'b0, ROW_PREDICT, '0},
			'{BLR_WORD, 1'b1, ROW_PREDICT, '0},
			'{32'h1234_5678, 1'b0, ROW_PREDICT, '0},
			'{32'h0000_0000, 1'b0, ROW_PREDICT, '0},
			'{32'h7C08_02A6, 1'b1, ROW_PREDICT, '0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			pss_result_t fn;
			send_word(dir_rows[i].word, dir_rows[i].last);
			if (scan_word(dir_rows[i].word, dir_rows[i].last, fn) &&
					dir_rows[i].kind == ROW_PREDICT)
				expect_function(fn);
			if (dir_rows[i].kind == ROW_RESULT)
				expect_function(dir_rows[i].res);
			if (dir_rows[i].last)
				images++;
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle = 26; recv_idle = 68; end
				1: begin send_idle = 68; recv_idle = 26; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			drain();
			case (phase)
				0: write_base(32'hFFFF_FFFF);
				1: write_base($urandom);
				default: write_base(32'hFFFF_FFFC);
			endcase
			target = DIR_N + (phase + 1) * RANDOM_WORDS / 3;
			while (words_sent < target) begin
				run_image();
				if ($urandom_range(4) == 0) begin
					drain();
					write_base(pick_base());
				end
			end
		end

		drain();
		$display("scanned %0d words in %0d images under %0d base address settings",
			words_sent, images, base_writes);
		$display("%0d functions compared, %0d of them cut off by the image end",
			functions_seen, cut_functions);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
src/pss_pkg.sv
src/pss_opcode_mask.sv
src/pss_scan_core.sv
src/ppc_function_signature_scanner.sv
tb/sv/ppc_function_signature_scanner_tb.sv
